>>> rtl/core/jfps_pkg.sv
// Shared constants for the four-point Jacobi stencil: default sizes,
// configuration register map and reset values. No dependencies.
`default_nettype none

package jfps_pkg;

    // Default structural parameters.
    localparam int MAX_COLS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration register widths.
    localparam int COLS_W = 11;
    localparam int ROWS_W = 16;

    // Row counter needs one bit beyond the row register to reach rows+2.
    localparam int ROW_CNT_W = ROWS_W + 1;

    // APB data and address widths.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    // Register reset values.
    localparam logic [COLS_W-1:0] COLS_RST = COLS_W'(1024);
    localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'(1024);

endpackage : jfps_pkg

`default_nettype wire

>>> rtl/core/jacobi_four_point_stencil.sv
// Streaming four-point Jacobi relaxation over a raster-order grid with halo.
// Depends on jfps_pkg for default sizes and the configuration register map.
//
// Usage:
//   Grid samples enter on the s_axis channel in raster order, halo ring
//   included, one sample per transfer; s_axis_tuser marks the first sample
//   of a frame and restarts the row and column counters. For every sample
//   at row r >= 2 and interior column c, one result leaves on the m_axis
//   channel: the quarter of the four-neighbour sum of interior point
//   (r-1, c), with m_axis_tlast set on the final interior point.
//   Halo samples and samples after the frame's end produce no transfer.
//   Throughput is one sample per clock cycle. A result reaches m_axis by
//   way of the store-read stage and the output register: the transfer
//   edge registers the sample together with its line-store reads, and the
//   adder tree's sum is loaded into the output register when that stage advances.
//   When the receiver stalls, the output register and the store-read stage
//   both hold, so two samples may be taken before s_axis_tready falls.
//   Reset clears the counters and the line-store fill mark, so unwritten
//   store entries read as zero without a clearing pass; the configuration
//   registers return to 1024 rows and 1024 columns.
//   Configuration (column and row counts) is written over the APB port at
//   byte addresses 0 and 4 while the stream is quiet.
`default_nettype none

module jacobi_four_point_stencil
    import jfps_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // s_axis_tdata: [SAMPLE_BITS-1:0] sample_value, upper bits unused.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // s_axis_tuser: [0] frame_start.
    input  wire logic                          s_axis_tuser,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,

    // m_axis_tdata: [SAMPLE_BITS-1:0] new_value, upper bits zero.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // m_axis_tlast: last_of_sweep.
    output logic                               m_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_AW-1:0]             paddr,
    input  wire logic [APB_DW-1:0]             pwdata,
    output logic [APB_DW-1:0]                  prdata,
    output logic                               pready
);

    localparam int TDW   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH = MAX_COLS + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int SUMW  = SAMPLE_BITS + 2;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic              cfg_wr;
    logic              reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= COLS_RST;
            rows_reg <= ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_COLS: cols_reg <= pwdata[COLS_W-1:0];
                REG_ROWS: rows_reg <= pwdata[ROWS_W-1:0];
                default:  cols_reg <= cols_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLS: prdata = APB_DW'(cols_reg);
            REG_ROWS: prdata = APB_DW'(rows_reg);
            default:  prdata = '0;
        endcase
    end

    // Effective sizes: a zero count acts as one, and columns are capped
    // at the line-store width.
    logic [AW-1:0]        cols_eff;
    logic [AW-1:0]        cols_p1;
    logic [ROW_CNT_W-1:0] rows_p1;
    logic [ROW_CNT_W-1:0] rows_p2;

    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = AW'(1);
        else if (32'(cols_reg) > 32'(MAX_COLS))
            cols_eff = AW'(MAX_COLS);
        else
            cols_eff = AW'(cols_reg);
        cols_p1 = cols_eff + AW'(1);
        if (rows_reg == '0)
            rows_p1 = ROW_CNT_W'(2);
        else
            rows_p1 = ROW_CNT_W'(rows_reg) + ROW_CNT_W'(1);
        rows_p2 = rows_p1 + ROW_CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Position counters, advanced at each input transfer.
    // ------------------------------------------------------------------
    logic [ROW_CNT_W-1:0]   row_cnt_reg;
    logic [AW-1:0]          col_cnt_reg;
    logic [ROW_CNT_W-1:0]   row_cnt_next;
    logic [AW-1:0]          col_cnt_next;
    logic [ROW_CNT_W-1:0]   row0;
    logic [ROW_CNT_W-1:0]   row1;
    logic [AW-1:0]          col0;
    logic [AW-1:0]          col1;
    logic                   beyond_end;
    logic                   in_res;
    logic                   in_last;
    logic                   s_acc;
    logic [SAMPLE_BITS-1:0] sample_in;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign sample_in = s_axis_tdata[SAMPLE_BITS-1:0];

    always_comb
    begin
        row0 = s_axis_tuser ? '0 : row_cnt_reg;
        col0 = s_axis_tuser ? '0 : col_cnt_reg;
        // A column count left past the row end by a size change wraps.
        if (col0 > cols_p1)
        begin
            col1 = '0;
            row1 = row0 + ROW_CNT_W'(1);
        end
        else
        begin
            col1 = col0;
            row1 = row0;
        end
        beyond_end = (row1 > rows_p1);
        in_res  = !beyond_end && (row1 >= ROW_CNT_W'(2)) &&
                  (col1 != '0) && (col1 <= cols_eff);
        in_last = (row1 == rows_p1) && (col1 == cols_eff);
        if (beyond_end)
        begin
            row_cnt_next = rows_p2;
            col_cnt_next = col1;
        end
        else if (col1 >= cols_p1)
        begin
            row_cnt_next = row1 + ROW_CNT_W'(1);
            col_cnt_next = '0;
        end
        else
        begin
            row_cnt_next = row1;
            col_cnt_next = col1 + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (s_acc)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The older store holds two rows back, the previous
    // store one row back, both indexed by column. Entries are written in
    // ascending column order from column zero, so the written entries
    // always form a prefix; fill_reg marks its end and anything above
    // it reads as zero.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] older_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] prev_mem  [DEPTH];
    logic [SAMPLE_BITS-1:0] older_rd_reg;
    logic [SAMPLE_BITS-1:0] prev_rd_reg;
    logic [SAMPLE_BITS-1:0] right_rd_reg;
    logic [AW-1:0]          rd_right_addr;
    logic [FW-1:0]          fill_reg;
    logic [FW-1:0]          fill_next;

    // Store-read stage registers.
    logic                   s1_valid_reg;
    logic                   s1_store_reg;
    logic                   s1_res_reg;
    logic                   s1_last_reg;
    logic [AW-1:0]          s1_col_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   up_fwd_reg,  up_ok_reg;
    logic                   cur_fwd_reg, cur_ok_reg;
    logic                   rgt_fwd_reg, rgt_ok_reg;
    logic [SAMPLE_BITS-1:0] fwd_old_reg;
    logic [SAMPLE_BITS-1:0] fwd_prev_reg;
    logic [SAMPLE_BITS-1:0] left_reg;

    logic                   s1_adv;
    logic                   st_we;
    logic [SAMPLE_BITS-1:0] up_val;
    logic [SAMPLE_BITS-1:0] cur_val;
    logic [SAMPLE_BITS-1:0] rgt_val;

    // The right neighbour is only needed for interior columns; at the
    // halo column the read address is held in range.
    assign rd_right_addr = (col1 < AW'(MAX_COLS + 1)) ? col1 + AW'(1) : col1;

    // The store-read stage writes back when it hands its sample on.
    assign st_we     = s1_adv && s1_store_reg;
    assign fill_next = (st_we && (FW'(s1_col_reg) == fill_reg)) ?
                       fill_reg + FW'(1) : fill_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            older_mem[s1_col_reg] <= cur_val;
            prev_mem[s1_col_reg]  <= s1_sample_reg;
        end
        if (s_acc)
        begin
            older_rd_reg <= older_mem[col1];
            prev_rd_reg  <= prev_mem[col1];
            right_rd_reg <= prev_mem[rd_right_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // Store-read stage control. A write landing at the same edge as a read
    // of the same entry is forwarded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_store_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (s_acc)
        begin
            s1_valid_reg <= 1'b1;
            s1_store_reg <= !beyond_end;
            s1_res_reg   <= in_res;
            s1_last_reg  <= in_last;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_col_reg    <= col1;
            s1_sample_reg <= sample_in;
            up_fwd_reg    <= st_we && (col1 == s1_col_reg);
            cur_fwd_reg   <= st_we && (col1 == s1_col_reg);
            rgt_fwd_reg   <= st_we && (rd_right_addr == s1_col_reg);
            up_ok_reg     <= FW'(col1) < fill_next;
            cur_ok_reg    <= FW'(col1) < fill_next;
            rgt_ok_reg    <= FW'(rd_right_addr) < fill_next;
            fwd_old_reg   <= cur_val;
            fwd_prev_reg  <= s1_sample_reg;
        end
        // The left neighbour is the older-store entry written by the
        // sample just before, one column to the left.
        if (st_we)
            left_reg <= cur_val;
    end

    always_comb
    begin
        if (up_fwd_reg)
            up_val = fwd_old_reg;
        else if (up_ok_reg)
            up_val = older_rd_reg;
        else
            up_val = '0;
        if (cur_fwd_reg)
            cur_val = fwd_prev_reg;
        else if (cur_ok_reg)
            cur_val = prev_rd_reg;
        else
            cur_val = '0;
        if (rgt_fwd_reg)
            rgt_val = fwd_prev_reg;
        else if (rgt_ok_reg)
            rgt_val = right_rd_reg;
        else
            rgt_val = '0;
    end

    // ------------------------------------------------------------------
    // Sum and output register.
    // ------------------------------------------------------------------
    logic [SUMW-1:0]        nb_sum;
    logic                   o_valid_reg;
    logic [SAMPLE_BITS-1:0] o_data_reg;
    logic                   o_last_reg;

    assign nb_sum = SUMW'(up_val) + SUMW'(left_reg) + SUMW'(rgt_val) +
                    SUMW'(s1_sample_reg);

    assign s1_adv        = s1_valid_reg && (!s1_res_reg || !o_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (s1_adv && s1_res_reg)
            o_valid_reg <= 1'b1;
        else if (m_axis_tready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_res_reg)
        begin
            o_data_reg <= nb_sum[SUMW-1:2];
            o_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = TDW'(o_data_reg);
    assign m_axis_tlast  = o_last_reg;

`ifndef SYNTHESIS
    // Stores are only ever written at or below the fill mark.
    a_prefix_write: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> (FW'(s1_col_reg) <= fill_reg))
        else $error("line store written above its fill mark");

    // Input back-pressure only when both stages are occupied.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && o_valid_reg && s1_res_reg))
        else $error("input stalled with a free stage");

    // The column counter never leaves the line-store range.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_cnt_reg) <= 32'(MAX_COLS + 1))
        else $error("column counter out of range");

    // The fill mark grows by at most one entry per cycle.
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + FW'(1)))
        else $error("fill mark moved by more than one entry");
`endif

endmodule : jacobi_four_point_stencil

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the streaming four-point Jacobi stencil.
// Needs jfps_pkg and jacobi_four_point_stencil; it predicts relaxed points or
// takes them from its directed table, and compares what leaves the m_axis channel.
`timescale 1ns / 1ps

module testbench;
    import jfps_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int MAX_COLS    = MAX_COLS_DEF;
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int LINE_DEPTH  = MAX_COLS + 2;

    // Samples that must fall inside a frame before the random part stops.
    localparam int RANDOM_ITEMS = 480;
    // Frame numbers of the random part that carry the two pressure events.
    localparam int PAUSE_FRAME = 5;
    localparam int HOLD_FRAME  = 8;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_GAP     = 12;
    localparam int DRAIN_CYCLES = 6;

    // How a row of the directed table is checked.
    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_NONE,
        CHECK_TYPED
    } check_kind_e;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   start;
        check_kind_e            kind;
        logic [SAMPLE_BITS-1:0] exp_value;
        logic                   exp_last;
    } directed_row_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] new_value;
        logic                   last_of_sweep;
    } relaxed_point_t;

    // The directed part runs with one interior row and one interior column,
    // so each frame is a 3 by 3 grid and its only result comes with the
    // eighth sample. The first frame follows reset without a frame start;
    // then one sample after the frame's end must be ignored; then a frame
    // is cut short by a new frame start, whose all-zero frame must relax
    // to zero regardless of what the line stores held before.
    localparam int DIRECTED_LEN = 21;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'hFFFFFF, 1'b0, CHECK_TYPED,     24'hFFFFFF, 1'b1},
        '{24'hFFFFFF, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h5A5A5A, 1'b0, CHECK_NONE,      24'h000000, 1'b0},
        '{24'h000001, 1'b1, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h800000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b1, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0},
        '{24'h000000, 1'b0, CHECK_TYPED,     24'h000000, 1'b1},
        '{24'h000000, 1'b0, CHECK_PREDICTED, 24'h000000, 1'b0}
    };

    // Every input of the block starts at a known value.
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [APB_AW-1:0]   paddr         = '0;
    logic [APB_DW-1:0]   pwdata        = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Predictor state: the two line stores, the raster position of the next
    // sample and the testbench's own copy of the two size registers.
    logic [SAMPLE_BITS-1:0] older_line  [LINE_DEPTH];
    logic [SAMPLE_BITS-1:0] recent_line [LINE_DEPTH];
    int                     grid_row;
    int                     grid_col;
    logic [COLS_W-1:0]      cfg_cols;
    logic [ROWS_W-1:0]      cfg_rows;

    relaxed_point_t pending_points [$];
    int             mismatch_count  = 0;
    int             samples_taken   = 0;
    // Shared between the sender and the receiver: burst_mode drops all idle
    // cycles on both sides, hold_off_cycles asks the receiver for one long
    // stall that it counts down itself.
    bit             burst_mode      = 1'b0;
    int             hold_off_cycles = 0;

    jacobi_four_point_stencil u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (older_line[i])
        begin
            older_line[i]  = '0;
            recent_line[i] = '0;
        end
        grid_row = 0;
        grid_col = 0;
        cfg_cols = COLS_RST;
        cfg_rows = ROWS_RST;
    end

    // Sizes as the block applies them: a zero count acts as one, and more
    // columns than the line stores can hold act as the maximum.
    function automatic int eff_cols();
        if (cfg_cols == '0)
            return 1;
        if (int'(cfg_cols) > MAX_COLS)
            return MAX_COLS;
        return int'(cfg_cols);
    endfunction

    function automatic int eff_rows();
        return (cfg_rows == '0) ? 1 : int'(cfg_rows);
    endfunction

    // Advances the predictor by one sample. Returns 1 when the sample
    // completes an interior point; in_frame is 0 for a sample that falls
    // after the frame's end and is therefore dropped.
    function automatic bit relax_sample(input logic [SAMPLE_BITS-1:0] sample,
                                        input bit start,
                                        output logic [SAMPLE_BITS-1:0] relaxed,
                                        output logic sweep_end,
                                        output bit in_frame);
        int cols;
        int rows;
        int r;
        int c;
        bit hit;
        logic [SAMPLE_BITS+1:0] sum;

        cols      = eff_cols();
        rows      = eff_rows();
        relaxed   = '0;
        sweep_end = 1'b0;
        in_frame  = 1'b0;
        hit       = 1'b0;
        if (start)
        begin
            grid_row = 0;
            grid_col = 0;
        end
        // A column count left beyond the row's end by a size change wraps.
        if (grid_col > cols + 1)
        begin
            grid_col = 0;
            grid_row++;
        end
        if (grid_row > rows + 1)
        begin
            grid_row = rows + 2;
            return 1'b0;
        end
        in_frame = 1'b1;
        r = grid_row;
        c = grid_col;
        if (c < LINE_DEPTH)
        begin
            if (r >= 2 && c >= 1 && c <= cols)
            begin
                // Up and left come from the older store, right from the
                // recent one, and the arriving sample is the point below.
                sum = (SAMPLE_BITS+2)'(older_line[c]) + (SAMPLE_BITS+2)'(older_line[c-1])
                    + (SAMPLE_BITS+2)'(recent_line[c+1]) + (SAMPLE_BITS+2)'(sample);
                relaxed   = sum[SAMPLE_BITS+1:2];
                sweep_end = (r == rows + 1 && c == cols);
                hit       = 1'b1;
            end
            older_line[c]  = recent_line[c];
            recent_line[c] = sample;
        end
        if (c >= cols + 1)
        begin
            grid_col = 0;
            grid_row = r + 1;
        end
        else
            grid_col = c + 1;
        return hit;
    endfunction

    // Mostly full-range random, with the two extremes often enough that
    // four-neighbour sums carry into both spare bits.
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // A small random size for the random part, zero and one included. The
    // bits above the register's width are filled with noise.
    function automatic logic [APB_DW-1:0] random_size(input int top, input int width);
        int pick;

        case ($urandom_range(0, 5))
            0:       pick = 0;
            1:       pick = 1;
            default: pick = $urandom_range(2, top);
        endcase
        return ($urandom() << width) | APB_DW'(pick);
    endfunction

    // APB write: the setup phase, then the access phase, which completes on
    // the edge at which pready is seen high.
    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLS)
            cfg_cols = word[COLS_W-1:0];
        else
            cfg_rows = word[ROWS_W-1:0];
    endtask

    // Offers one sample after a random gap and waits for its transfer. The
    // valid is only lowered when a gap follows, so a back-to-back sample
    // never sees it dropped and raised within one time step.
    task automatic feed_sample(input logic [SAMPLE_BITS-1:0] sample, input bit start,
                               input check_kind_e kind,
                               input logic [SAMPLE_BITS-1:0] exp_value,
                               input logic exp_last);
        int gap;
        bit hit;
        bit in_frame;
        relaxed_point_t point;

        gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(sample);
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (!s_axis_tready);
        hit = relax_sample(sample, start, point.new_value, point.last_of_sweep, in_frame);
        if (in_frame)
            samples_taken++;
        case (kind)
            CHECK_PREDICTED:
                if (hit)
                    pending_points.push_back(point);
            CHECK_TYPED:
                pending_points.push_back('{new_value: exp_value, last_of_sweep: exp_last});
            default: ;
        endcase
    endtask

    task automatic feed_random(input bit start);
        feed_sample(random_sample(), start, CHECK_PREDICTED, '0, 1'b0);
    endtask

    // Stops offering samples and waits until every expected point has left
    // the block, then waits further so that halo samples still in the pipeline
    // are through before a register changes.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: checks each m_axis transfer against the oldest expectation,
    // then stalls for a freshly drawn number of cycles. Signals are read
    // straight after the edge, before any update of that edge lands.
    initial
    begin : receiver
        int stall_left;
        relaxed_point_t want;

        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("new_value: expected nothing, actual 0x%06h",
                           m_axis_tdata[SAMPLE_BITS-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.new_value)
                    begin
                        $error("new_value: expected 0x%06h, actual 0x%06h",
                               want.new_value, m_axis_tdata[SAMPLE_BITS-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last_of_sweep)
                    begin
                        $error("last_of_sweep: expected %0b, actual %0b",
                               want.last_of_sweep, m_axis_tlast);
                        mismatch_count++;
                    end
                end
                stall_left = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int frame_no;
        int frame_len;
        int form;

        frame_no = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a 3 by 3 grid.
        write_reg(REG_COLS, 32'd1);
        write_reg(REG_ROWS, 32'd1);
        for (int i = 0; i < DIRECTED_LEN; i++)
            feed_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].start,
                        DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].exp_value,
                        DIRECTED_ROWS[i].exp_last);

        // The largest row count: a long frame that is never finished. Then
        // shrinking the row count mid-frame ends it, so the next samples
        // are dropped.
        settle();
        write_reg(REG_ROWS, 32'd65535);
        feed_random(1'b1);
        repeat (119) feed_random(1'b0);
        settle();
        write_reg(REG_ROWS, 32'd3);
        repeat (5) feed_random(1'b0);

        // Shrinking the column count mid-row: the column position beyond
        // the new end wraps into the next row.
        settle();
        write_reg(REG_COLS, 32'd10);
        write_reg(REG_ROWS, 32'd65535);
        feed_random(1'b1);
        repeat (43) feed_random(1'b0);
        settle();
        write_reg(REG_COLS, 32'd3);
        repeat (30) feed_random(1'b0);

        settle();
        write_reg(REG_COLS, 32'd1024);
        write_reg(REG_ROWS, 32'd1);
        feed_random(1'b1);
        repeat (39) feed_random(1'b0);
        settle();
        write_reg(REG_COLS, 32'd4);
        repeat (20) feed_random(1'b0);

        // One full row at the widest size: an over-large column count acts
        // as MAX_COLS, so the row wraps after as many samples as a store holds,
        // and a zero row count acts as one row. Three samples of
        // the next row follow; shrinking the columns to one then wraps into
        // the last row, whose only point reads neighbours from both wide
        // rows. Two samples beyond the frame's end are dropped.
        settle();
        write_reg(REG_COLS, 32'd2047);
        write_reg(REG_ROWS, 32'd0);
        feed_random(1'b1);
        repeat (MAX_COLS + 4) feed_random(1'b0);
        settle();
        write_reg(REG_COLS, 32'd1);
        repeat (5) feed_random(1'b0);

        settle();
        write_reg(REG_COLS, 32'd0);
        write_reg(REG_ROWS, 32'd2);
        feed_random(1'b1);
        repeat (11) feed_random(1'b0);

        // Random part: mostly well-formed frames on small grids, with some
        // frames cut short by a new frame start and some bursts of noise.
        samples_taken = 0;
        while (samples_taken < RANDOM_ITEMS)
        begin
            frame_no++;
            burst_mode = ($urandom_range(0, 4) == 0);
            form       = $urandom_range(0, 9);
            if (frame_no == HOLD_FRAME)
            begin
                // The receiver stalls for a long stretch while the sender
                // keeps offering, so the block fills and stops taking input.
                settle();
                write_reg(REG_COLS, 32'd6);
                write_reg(REG_ROWS, 32'd6);
                burst_mode      = 1'b1;
                hold_off_cycles = HOLD_CYCLES;
                form            = 0;
            end
            else if (frame_no == 1 || $urandom_range(0, 2) == 0)
            begin
                settle();
                write_reg(REG_COLS, random_size(12, COLS_W));
                write_reg(REG_ROWS, random_size(6, ROWS_W));
            end
            frame_len = (eff_cols() + 2) * (eff_rows() + 2);
            if (form <= 7)
            begin
                feed_random(1'b1);
                for (int i = 1; i < frame_len; i++)
                begin
                    // At most once, the sender halts mid-frame until every
                    // expected point has arrived.
                    if (frame_no == PAUSE_FRAME && i == frame_len / 2)
                        settle();
                    feed_random(1'b0);
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) feed_random(1'b0);
            end
            else if (form == 8)
            begin
                feed_random(1'b1);
                repeat ($urandom_range(0, frame_len - 2)) feed_random(1'b0);
            end
            else
                repeat ($urandom_range(1, 20)) feed_random($urandom_range(0, 7) == 0);
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Generous bound on the whole run; a hang in either handshake ends here.
    initial
    begin : watchdog
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
